[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/atcl_pkg.sv]
// Types, codes and constants of the AT command line classifier.
package atcl_pkg;

  localparam int MAX_NAME_LEN_DEF  = 6;
  localparam int TABLE_ENTRIES_DEF = 7;

  localparam int NUM_ENTRY_REGS = 7;
  localparam int CHAR_W         = 8;
  localparam int LEN_W          = 3;
  localparam int COUNT_W        = 3;
  localparam int INDEX_W        = 3;
  localparam int CFG_INDEX_W    = 3;
  localparam int ENTRY_W        = 55;
  localparam int ENTRY_LEN_LSB  = 48;
  localparam int ENTRY_CAP_LSB  = 51;
  localparam int CAP_W          = 4;

  localparam logic [LEN_W-1:0] LEN_OVERLONG = 3'd7;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_BASE  = 3'd1;

  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 3'd4;

  localparam logic [ENTRY_W-1:0] ENTRY_RESET [NUM_ENTRY_REGS] = '{
    55'd2251799813685248,   // empty name, exec
    55'd18295873486192709,  // E, setup
    55'd3377701135274539,   // +RST, exec
    55'd3377701101324075,   // +GMR, exec
    55'd0,
    55'd0,
    55'd0
  };

  typedef enum logic [2:0] {
    KIND_EXEC  = 3'd0,
    KIND_QUERY = 3'd1,
    KIND_TEST  = 3'd2,
    KIND_SETUP = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_NAME  = 3'd0,
    PH_QUERY = 3'd1,
    PH_EQ    = 3'd2,
    PH_EQQ   = 3'd3,
    PH_SETUP = 3'd4,
    PH_BAD   = 3'd5
  } phase_t;

  // What the line tracker reports about the current character.
  typedef struct packed {
    logic             cr;
    kind_t            kind;
    logic [LEN_W-1:0] len;
  } line_end_t;

endpackage

[hw/rtl/at_command_line_classifier.sv]
// AT command line classifier: takes one character per cycle and reports the
// class of the line (exec, query, test, setup or error) and the matched command
// table entry when the closing carriage return has been processed. Characters
// are taken at one per clock while in_stall is low; a character goes into an
// input register and is processed from there, so the result register is
// loaded when the carriage return in the input register is processed, and the
// result is offered from then on. The table compare against all entries runs
// in parallel while that character is processed. in_stall rises only while a
// carriage return waits in the input register and the result register is
// full and stalled. Table and entry count are written through the cfg port; the
// user must write them only while the block is idle (not enforced here).
module at_command_line_classifier
  import atcl_pkg::*;
#(
  parameter int MAX_NAME_LEN  = MAX_NAME_LEN_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAR_W-1:0]      in_character,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_kind,
  output logic [INDEX_W-1:0]     out_entry_index,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ENTRY_W-1:0]     cfg_data
);

  `include "assert_macros.svh"

  logic                      in_valid_r;
  logic [CHAR_W-1:0]         char_r;
  logic                      out_valid_r;
  kind_t                     out_kind_r;
  logic [INDEX_W-1:0]        out_index_r;
  logic [COUNT_W-1:0]        count_r;
  logic [ENTRY_W-1:0]        entry_r [TABLE_ENTRIES];

  line_end_t                 line_end;
  logic [8*MAX_NAME_LEN-1:0] name;
  kind_t                     match_kind;
  logic [INDEX_W-1:0]        match_index;
  logic                      out_free;
  logic                      stage_ok;
  logic                      step;

  assign out_free = !out_valid_r || !out_stall;
  assign stage_ok = !line_end.cr || out_free;
  assign step     = in_valid_r && stage_ok;
  assign in_stall = in_valid_r && !stage_ok;

  atcl_line_fsm #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .character (char_r),
    .line_end  (line_end),
    .name      (name)
  );

  atcl_match #(
    .MAX_NAME_LEN  (MAX_NAME_LEN),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_match (
    .line_end    (line_end),
    .name        (name),
    .entry_count (count_r),
    .entries     (entry_r),
    .kind        (match_kind),
    .entry_index (match_index)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) char_r <= in_character;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && line_end.cr) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && line_end.cr) begin
      out_kind_r  <= match_kind;
      out_index_r <= match_index;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_entry_index = out_index_r;

  // configuration registers; entries past the table size are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= ENTRY_COUNT_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) entry_r[i] <= ENTRY_RESET[i];
    end else if (cfg_write_en) begin
      if (cfg_index == REG_ENTRY_COUNT) count_r <= cfg_data[COUNT_W-1:0];
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cfg_index == REG_ENTRY_BASE + CFG_INDEX_W'(i)) entry_r[i] <= cfg_data;
      end
    end
  end

  `ASSERT_IMPL(a_error_index_zero, out_valid_r && out_kind_r == KIND_ERROR,
               out_index_r == '0)
  `ASSERT_IMPL(a_index_in_table, out_valid_r,
               out_index_r < INDEX_W'(TABLE_ENTRIES))
  `ASSERT_NEXT(a_blocked_cr_held, in_valid_r && line_end.cr && !out_free,
               in_valid_r && line_end.cr && $stable(char_r))

endmodule

[hw/rtl/atcl_line_fsm.sv]
// Line phase tracking and name collection.
module atcl_line_fsm
  import atcl_pkg::*;
#(
  parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [CHAR_W-1:0]         character,
  output line_end_t                 line_end,
  output logic [8*MAX_NAME_LEN-1:0] name
);

  localparam int NAME_W = 8 * MAX_NAME_LEN;

  phase_t              phase_r, phase_nxt;
  logic [NAME_W-1:0]   name_r, name_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                is_cr, is_digit, is_name_char;

  assign is_cr    = (character == CH_CR);
  assign is_digit = (character inside {[CH_0:CH_9]});
  assign is_name_char = !is_cr && (character != CH_QUERY) && (character != CH_EQ) && !is_digit;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_NAME: begin
        if (is_cr) phase_nxt = PH_NAME;
        else if (character == CH_QUERY) phase_nxt = PH_QUERY;
        else if (character == CH_EQ) phase_nxt = PH_EQ;
        else if (is_digit) phase_nxt = PH_SETUP;
      end
      PH_QUERY: phase_nxt = is_cr ? PH_NAME : PH_BAD;
      PH_EQ: begin
        if (is_cr) phase_nxt = PH_NAME;
        else if (character == CH_QUERY) phase_nxt = PH_EQQ;
        else phase_nxt = PH_SETUP;
      end
      PH_EQQ:   phase_nxt = is_cr ? PH_NAME : PH_SETUP;
      PH_SETUP: phase_nxt = is_cr ? PH_NAME : PH_SETUP;
      default:  phase_nxt = is_cr ? PH_NAME : PH_BAD;
    endcase
  end

  // outputs
  always_comb begin
    line_end.cr  = is_cr;
    line_end.len = len_r;
    case (phase_r)
      PH_NAME:  line_end.kind = KIND_EXEC;
      PH_QUERY: line_end.kind = KIND_QUERY;
      PH_EQ:    line_end.kind = KIND_SETUP;
      PH_EQQ:   line_end.kind = KIND_TEST;
      PH_SETUP: line_end.kind = KIND_SETUP;
      default:  line_end.kind = KIND_ERROR;
    endcase
  end

  assign name = name_r;

  always_comb begin
    name_nxt = name_r;
    len_nxt  = len_r;
    if (is_cr) begin
      name_nxt = '0;
      len_nxt  = '0;
    end else if (phase_r == PH_NAME && is_name_char) begin
      if (len_r < LEN_W'(MAX_NAME_LEN)) begin
        for (int b = 0; b < MAX_NAME_LEN; b++) begin
          if (len_r == LEN_W'(b)) name_nxt[8*b +: 8] = character;
        end
        len_nxt = len_r + LEN_W'(1);
      end else begin
        len_nxt = LEN_OVERLONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NAME;
      name_r  <= '0;
      len_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      name_r  <= name_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

[hw/rtl/atcl_match.sv]
// Command table lookup and capability check.
module atcl_match
  import atcl_pkg::*;
#(
  parameter int MAX_NAME_LEN  = MAX_NAME_LEN_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  line_end_t                 line_end,
  input  logic [8*MAX_NAME_LEN-1:0] name,
  input  logic [COUNT_W-1:0]        entry_count,
  input  logic [ENTRY_W-1:0]        entries [TABLE_ENTRIES],
  output kind_t                     kind,
  output logic [INDEX_W-1:0]        entry_index
);

  logic [COUNT_W-1:0]       count;
  logic [TABLE_ENTRIES-1:0] hit;
  logic                     found;
  logic [INDEX_W-1:0]       idx;
  logic [CAP_W-1:0]         caps;
  logic                     len_ok;

  assign count  = (entry_count > COUNT_W'(TABLE_ENTRIES)) ? COUNT_W'(TABLE_ENTRIES)
                                                          : entry_count;
  assign len_ok = (line_end.len != '0) && (line_end.len <= LEN_W'(MAX_NAME_LEN));

  // bytes past the name length are don't-care
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i] = (entries[i][ENTRY_LEN_LSB +: LEN_W] == line_end.len) &&
               (COUNT_W'(i) < count);
      for (int b = 0; b < MAX_NAME_LEN; b++) begin
        if (LEN_W'(b) < line_end.len && entries[i][8*b +: 8] != name[8*b +: 8])
          hit[i] = 1'b0;
      end
    end
  end

  // lowest matching entry from 1 up; entry 0 only for an empty name
  always_comb begin
    found = 1'b0;
    idx   = '0;
    caps  = '0;
    if (line_end.len == '0) begin
      found = (count != '0);
      caps  = entries[0][ENTRY_CAP_LSB +: CAP_W];
    end else if (len_ok) begin
      for (int i = TABLE_ENTRIES - 1; i >= 1; i--) begin
        if (hit[i]) begin
          found = 1'b1;
          idx   = INDEX_W'(i);
          caps  = entries[i][ENTRY_CAP_LSB +: CAP_W];
        end
      end
    end
  end

  always_comb begin
    kind        = KIND_ERROR;
    entry_index = '0;
    if (line_end.kind != KIND_ERROR && found && caps[line_end.kind[1:0]]) begin
      kind        = line_end.kind;
      entry_index = idx;
    end
  end

endmodule
